[rtl/core/x86_subset_byte_decoder_executor_assert.svh]
// Assertion macros shared by the decoder/executor modules
`ifndef X86_SUBSET_BYTE_DECODER_EXECUTOR_ASSERT_SVH
`define X86_SUBSET_BYTE_DECODER_EXECUTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define XSBD_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define XSBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/xsbd_pkg.sv]
// Shared types and constants for the x86 subset byte decoder/executor
package xsbd_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_ADD8  = 3'd1;
  localparam logic [2:0] K_ADD16 = 3'd2;
  localparam logic [2:0] K_MOV8  = 3'd3;
  localparam logic [2:0] K_MOV16 = 3'd4;
  localparam logic [2:0] K_HALT  = 3'd5;

  localparam logic [7:0] OP_ADD_R8   = 8'h02;
  localparam logic [7:0] OP_ADD_AX   = 8'h05;
  localparam logic [7:0] OP_GRP1     = 8'h81;
  localparam logic [7:0] OP_MOV8_HI5 = 8'hB0;
  localparam logic [7:0] OP_MOV16    = 8'hB8;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_INT      = 8'hCD;
  localparam logic [7:0] INT_EXIT    = 8'h20;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  dest;
    logic [2:0]  src;
    logic [15:0] imm;
    logic [15:0] next_off;
  } xsbd_op_t;

endpackage

[rtl/core/xsbd_front.sv]
// Front end: byte-serial instruction decoder and offset tracking
`include "x86_subset_byte_decoder_executor_assert.svh"

module xsbd_front
  import xsbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] code_byte,
  input  logic       q_full,
  output logic       push,
  output xsbd_op_t   push_op
);

  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_MODRM  = 3'd1;
  localparam logic [2:0] PH_IMM_LO = 3'd2;
  localparam logic [2:0] PH_IMM_HI = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_INT    = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  opcode, opcode_next;
  logic [7:0]  modrm, modrm_next;
  logic [7:0]  imm_lo, imm_lo_next;
  logic [15:0] offset;
  logic        halt, halt_next;
  logic        take;
  logic        emit;
  logic [2:0]  kind;
  logic [2:0]  dest;
  logic [2:0]  src;
  logic [15:0] imm;

  assign byte_ready = halt | ~q_full;
  assign take       = byte_valid & byte_ready & ~halt;

  always_comb begin
    phase_next  = phase;
    opcode_next = opcode;
    modrm_next  = modrm;
    imm_lo_next = imm_lo;
    halt_next   = halt;
    emit        = 1'b0;
    kind        = K_NONE;
    dest        = 3'd0;
    src         = 3'd0;
    imm         = 16'd0;
    unique case (phase)
      PH_OPCODE: begin
        opcode_next = code_byte;
        if (code_byte == OP_ADD_R8 || code_byte == OP_GRP1) begin
          phase_next = PH_MODRM;
        end else if (code_byte == OP_ADD_AX || code_byte[7:4] == OP_MOV8_HI5[7:4]) begin
          phase_next = PH_IMM_LO;
        end else if (code_byte == OP_ESC) begin
          phase_next = PH_SKIP;
        end else if (code_byte == OP_INT) begin
          phase_next = PH_INT;
        end else begin
          emit = 1'b1;
        end
      end
      PH_MODRM: begin
        modrm_next = code_byte;
        if (opcode == OP_GRP1) begin
          phase_next = PH_IMM_LO;
        end else begin
          phase_next = PH_OPCODE;
          emit       = 1'b1;
          if (code_byte[7:6] == 2'b11) begin
            kind = K_ADD8;
            dest = code_byte[5:3];
            src  = code_byte[2:0];
          end
        end
      end
      PH_IMM_LO: begin
        if (opcode[7:3] == OP_MOV8_HI5[7:3]) begin
          phase_next = PH_OPCODE;
          emit       = 1'b1;
          kind       = K_MOV8;
          dest       = opcode[2:0];
          imm        = {8'd0, code_byte};
        end else begin
          imm_lo_next = code_byte;
          phase_next  = PH_IMM_HI;
        end
      end
      PH_IMM_HI: begin
        phase_next = PH_OPCODE;
        emit       = 1'b1;
        imm        = {code_byte, imm_lo};
        if (opcode == OP_ADD_AX) begin
          kind = K_ADD16;
        end else if (opcode == OP_GRP1) begin
          if (modrm[7:3] == 5'b11000) begin
            kind = K_ADD16;
            dest = modrm[2:0];
          end
        end else if (opcode[7:3] == OP_MOV16[7:3]) begin
          kind = K_MOV16;
          dest = opcode[2:0];
        end
      end
      PH_SKIP: begin
        phase_next = PH_OPCODE;
        emit       = 1'b1;
      end
      PH_INT: begin
        phase_next = PH_OPCODE;
        emit       = 1'b1;
        if (code_byte == INT_EXIT) begin
          kind      = K_HALT;
          halt_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_OPCODE;
      end
    endcase
  end

  assign push             = take & emit;
  assign push_op.kind     = kind;
  assign push_op.dest     = dest;
  assign push_op.src      = src;
  assign push_op.imm      = imm;
  assign push_op.next_off = offset + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_OPCODE;
      opcode <= 8'd0;
      modrm  <= 8'd0;
      imm_lo <= 8'd0;
      offset <= 16'd0;
      halt   <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      opcode <= opcode_next;
      modrm  <= modrm_next;
      imm_lo <= imm_lo_next;
      offset <= offset + 16'd1;
      halt   <= halt_next;
    end
  end

  `XSBD_ASSERT_NEXT(a_halt_sticky, clk, rst, halt, halt, "halt flag cleared")
  `XSBD_ASSERT(a_no_push_halted, clk, rst, halt, !push, "word queued after halt")

endmodule

[rtl/core/xsbd_queue.sv]
// Small FIFO of decoded operations between front and back end
`include "x86_subset_byte_decoder_executor_assert.svh"

module xsbd_queue
  import xsbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  xsbd_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output xsbd_op_t head_op
);

  xsbd_op_t        entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `XSBD_ASSERT(a_pop_nonempty, clk, rst, pop, head_valid, "pop from empty queue")
  `XSBD_ASSERT(a_push_room, clk, rst, push, !full, "push into full queue")

endmodule

[rtl/core/xsbd_back.sv]
// Back end: register file read, execute, writeback and output register
`include "x86_subset_byte_decoder_executor_assert.svh"

module xsbd_back
  import xsbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  xsbd_op_t    head_op,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tlast
);

  logic [15:0] regs [8];
  logic [7:0]  reg_vld;
  logic        carry;

  logic        r_valid;
  xsbd_op_t    r_op;
  logic [15:0] rd_a, rd_b, byp;
  logic        hit_a, hit_b;
  logic        r_adv;
  logic [2:0]  a_idx, b_idx;

  logic [15:0] opa, opb;
  logic [7:0]  a_byte, b_byte, byte_val;
  logic [8:0]  sum8;
  logic [16:0] sum16;
  logic [15:0] merged;
  logic        wr, wr_en, is_byte, carry_next, last;
  logic [2:0]  wr_idx, dest_out;
  logic [15:0] wr_word, new_value;

  assign r_adv = r_valid & (~m_tvalid | m_tready);
  assign pop   = head_valid & (~r_valid | r_adv);

  always_comb begin
    if (head_op.kind == K_ADD8 || head_op.kind == K_MOV8) begin
      a_idx = {1'b0, head_op.dest[1:0]};
    end else begin
      a_idx = head_op.dest;
    end
    b_idx = {1'b0, head_op.src[1:0]};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_a  <= reg_vld[a_idx] ? regs[a_idx] : 16'd0;
      rd_b  <= reg_vld[b_idx] ? regs[b_idx] : 16'd0;
      r_op  <= head_op;
      hit_a <= wr_en && (wr_idx == a_idx);
      hit_b <= wr_en && (wr_idx == b_idx);
      byp   <= wr_word;
    end
    if (wr_en) begin
      regs[wr_idx] <= wr_word;
    end
  end

  assign opa      = hit_a ? byp : rd_a;
  assign opb      = hit_b ? byp : rd_b;
  assign a_byte   = r_op.dest[2] ? opa[15:8] : opa[7:0];
  assign b_byte   = r_op.src[2] ? opb[15:8] : opb[7:0];
  assign sum8     = {1'b0, a_byte} + {1'b0, b_byte};
  assign sum16    = {1'b0, opa} + {1'b0, r_op.imm};
  assign byte_val = (r_op.kind == K_ADD8) ? sum8[7:0] : r_op.imm[7:0];
  assign merged   = r_op.dest[2] ? {byte_val, opa[7:0]} : {opa[15:8], byte_val};

  always_comb begin
    wr         = 1'b0;
    is_byte    = 1'b0;
    carry_next = carry;
    last       = 1'b0;
    wr_idx     = r_op.dest;
    wr_word    = merged;
    new_value  = 16'd0;
    unique case (r_op.kind)
      K_ADD8: begin
        wr         = 1'b1;
        is_byte    = 1'b1;
        carry_next = sum8[8];
        wr_idx     = {1'b0, r_op.dest[1:0]};
        new_value  = {8'd0, byte_val};
      end
      K_MOV8: begin
        wr        = 1'b1;
        is_byte   = 1'b1;
        wr_idx    = {1'b0, r_op.dest[1:0]};
        new_value = {8'd0, byte_val};
      end
      K_ADD16: begin
        wr         = 1'b1;
        carry_next = sum16[16];
        wr_word    = sum16[15:0];
        new_value  = sum16[15:0];
      end
      K_MOV16: begin
        wr        = 1'b1;
        wr_word   = r_op.imm;
        new_value = r_op.imm;
      end
      K_HALT: begin
        last = 1'b1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  assign wr_en    = r_adv & wr;
  assign dest_out = wr ? r_op.dest : 3'd0;

  always_ff @(posedge clk) begin
    if (r_adv) begin
      m_tdata <= {2'b00, r_op.next_off, carry_next, new_value, is_byte, dest_out, wr};
      m_tlast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      carry    <= 1'b0;
      reg_vld  <= '0;
    end else begin
      if (pop) begin
        r_valid <= 1'b1;
      end else if (r_adv) begin
        r_valid <= 1'b0;
      end
      if (r_adv) begin
        m_tvalid <= 1'b1;
        carry    <= carry_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        reg_vld[wr_idx] <= 1'b1;
      end
    end
  end

  `XSBD_ASSERT(a_pop_has_room, clk, rst, pop, !r_valid || r_adv, "pop with stage busy")

endmodule

[rtl/core/x86_subset_byte_decoder_executor.sv]
// Top level of the x86 subset byte decoder/executor
// Usage:
//   s_* carries one code byte per word, in program order. m_* carries one
//   word for each finished instruction; bytes inside an instruction give none.
//   m_tlast is set on the word of the halting CD 20 instruction; after it all
//   input bytes are accepted and dropped until reset.
// Timing:
//   Steps after the edge that takes an instruction's last byte: decode into a
//   4-entry queue on that edge, register read, and execute into the output
//   register. One byte per cycle is sustained while the queue is not full; the
//   output register accepts a new word in the cycle the previous one is taken.
// Reset:
//   rst clears the register file (per-register valid bits), carry, decode
//   state, offset, queue and output. No clearing pass is needed.
// Stalls:
//   While m_tready is low the output register holds its word and the execute
//   stage holds one more; the queue absorbs up to 4 more finished
//   instructions, then s_tready drops.
module x86_subset_byte_decoder_executor
  import xsbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // code_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // reg_written, dest_reg[2:0], dest_is_byte, new_value[15:0], carry_flag,
  // next_offset[15:0], zero pad[1:0]
  output logic [39:0] m_tdata,
  output logic        m_tlast   // halted
);

  logic     q_full;
  logic     push;
  xsbd_op_t push_op;
  logic     pop;
  logic     head_valid;
  xsbd_op_t head_op;

  xsbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .code_byte  (s_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  xsbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  xsbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
